FILE: design/y2r_pkg.sv
package y2r_pkg;

  localparam int unsigned ProdW = 18;
  localparam int unsigned SumW  = 20;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } in_t;

  typedef struct packed {
    logic [7:0] first_lead;
    logic [7:0] first_mid;
    logic [7:0] first_tail;
    logic [7:0] second_lead;
    logic [7:0] second_mid;
    logic [7:0] second_tail;
    logic       frame_end_out;
  } out_t;

  typedef struct packed {
    logic signed [ProdW-1:0] luma0;
    logic signed [ProdW-1:0] luma1;
    logic signed [ProdW-1:0] red_v;
    logic signed [ProdW-1:0] grn_u;
    logic signed [ProdW-1:0] grn_v;
    logic signed [ProdW-1:0] blu_u;
    logic                    frame_end;
  } prod_t;

  typedef struct packed {
    logic signed [SumW-1:0] red0;
    logic signed [SumW-1:0] grn0;
    logic signed [SumW-1:0] blu0;
    logic signed [SumW-1:0] red1;
    logic signed [SumW-1:0] grn1;
    logic signed [SumW-1:0] blu1;
    logic                   frame_end;
  } sum_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } adv_t;

endpackage

FILE: design/y2r_mul.sv
module y2r_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  y2r_pkg::in_t   data_i,
  output y2r_pkg::prod_t prod_o
);

  logic signed [9:0] c0;
  logic signed [9:0] c1;
  logic signed [8:0] du;
  logic signed [8:0] ev;
  y2r_pkg::prod_t    prod_d;
  y2r_pkg::prod_t    prod_q;

  always_comb begin
    c0 = signed'({2'b00, data_i.luma_first}) - 10'sd16;
    c1 = signed'({2'b00, data_i.luma_second}) - 10'sd16;
    du = signed'({1'b0, data_i.chroma_blue}) - 9'sd128;
    ev = signed'({1'b0, data_i.chroma_red}) - 9'sd128;
    prod_d.luma0     = 18'(c0) * 18'sd298;
    prod_d.luma1     = 18'(c1) * 18'sd298;
    prod_d.red_v     = 18'(ev) * 18'sd409;
    prod_d.grn_u     = 18'(du) * 18'sd100;
    prod_d.grn_v     = 18'(ev) * 18'sd208;
    prod_d.blu_u     = 18'(du) * 18'sd516;
    prod_d.frame_end = data_i.frame_end_in;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: design/y2r_add.sv
module y2r_add (
  input  logic           clk_i,
  input  logic           en_i,
  input  y2r_pkg::prod_t prod_i,
  output y2r_pkg::sum_t  sum_o
);

  localparam logic signed [y2r_pkg::SumW-1:0] Round = y2r_pkg::SumW'(128);

  logic signed [y2r_pkg::SumW-1:0] y0;
  logic signed [y2r_pkg::SumW-1:0] y1;
  logic signed [y2r_pkg::SumW-1:0] r_off;
  logic signed [y2r_pkg::SumW-1:0] g_off;
  logic signed [y2r_pkg::SumW-1:0] b_off;
  y2r_pkg::sum_t sum_d;
  y2r_pkg::sum_t sum_q;

  always_comb begin
    y0    = y2r_pkg::SumW'(prod_i.luma0);
    y1    = y2r_pkg::SumW'(prod_i.luma1);
    r_off = y2r_pkg::SumW'(prod_i.red_v);
    g_off = -y2r_pkg::SumW'(prod_i.grn_u) - y2r_pkg::SumW'(prod_i.grn_v);
    b_off = y2r_pkg::SumW'(prod_i.blu_u);
    sum_d.red0      = y0 + r_off + Round;
    sum_d.grn0      = y0 + g_off + Round;
    sum_d.blu0      = y0 + b_off + Round;
    sum_d.red1      = y1 + r_off + Round;
    sum_d.grn1      = y1 + g_off + Round;
    sum_d.blu1      = y1 + b_off + Round;
    sum_d.frame_end = prod_i.frame_end;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: design/y2r_pack.sv
module y2r_pack (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          bgr_i,
  input  y2r_pkg::sum_t sum_i,
  output y2r_pkg::out_t data_o
);

  function automatic logic [7:0] sat(input logic signed [y2r_pkg::SumW-1:0] s);
    logic [7:0] res;
    if (s[y2r_pkg::SumW-1]) begin
      res = 8'h00;
    end else if (|s[y2r_pkg::SumW-2:16]) begin
      res = 8'hff;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  logic [7:0]    r0, g0, b0, r1, g1, b1;
  y2r_pkg::out_t data_d;
  y2r_pkg::out_t data_q;

  always_comb begin
    r0 = sat(sum_i.red0);
    g0 = sat(sum_i.grn0);
    b0 = sat(sum_i.blu0);
    r1 = sat(sum_i.red1);
    g1 = sat(sum_i.grn1);
    b1 = sat(sum_i.blu1);
    data_d.first_lead    = bgr_i ? b0 : r0;
    data_d.first_mid     = g0;
    data_d.first_tail    = bgr_i ? r0 : b0;
    data_d.second_lead   = bgr_i ? b1 : r1;
    data_d.second_mid    = g1;
    data_d.second_tail   = bgr_i ? r1 : b1;
    data_d.frame_end_out = sum_i.frame_end;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

FILE: design/yuyv_to_rgb24_converter.sv
// YUYV 4:2:2 macropixel to two RGB24 pixels, integer BT.601 limited range.
// Input channel: in_valid_i / in_stall_o / in_data_i carry one macropixel
// (Y0, U, Y1, V and a frame-end flag) per transfer.
// Output channel: out_valid_o / out_stall_i / out_data_o carry the two
// converted pixels and the frame-end flag per transfer.
// cfg_we_i / cfg_wdata_i write the byte-order bit (0: R,G,B; 1: B,G,R);
// write it only while the pipeline is empty.
// Three stages lie between input transfer and out_valid_o: multiply,
// sum, and clamp and byte-order, each registered.
// Throughput: one macropixel per cycle while out_stall_i is low; each
// stage holds one item and moves it whenever the next is empty or moving.
// Stall: when out_stall_i is high the output item holds; the stages behind
// it keep filling bubbles, and in_stall_o rises only once all three
// stages hold items.
// Reset: clears all stage valid bits and the byte-order bit to RGB.
module yuyv_to_rgb24_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  y2r_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output y2r_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  logic           v1_q, v2_q, v3_q;
  logic           v1_d, v2_d, v3_d;
  logic           bgr_q, bgr_d;
  y2r_pkg::adv_t  adv;
  y2r_pkg::prod_t prod;
  y2r_pkg::sum_t  sum;

  always_comb begin
    adv.adv3 = !v3_q || !out_stall_i;
    adv.adv2 = !v2_q || adv.adv3;
    adv.adv1 = !v1_q || adv.adv2;
    v1_d  = adv.adv1 ? in_valid_i : v1_q;
    v2_d  = adv.adv2 ? v1_q : v2_q;
    v3_d  = adv.adv3 ? v2_q : v3_q;
    bgr_d = cfg_we_i ? cfg_wdata_i : bgr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      bgr_q <= 1'b0;
    end else begin
      v1_q  <= v1_d;
      v2_q  <= v2_d;
      v3_q  <= v3_d;
      bgr_q <= bgr_d;
    end
  end

  y2r_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (adv.adv1),
    .data_i (in_data_i),
    .prod_o (prod)
  );

  y2r_add u_add (
    .clk_i  (clk_i),
    .en_i   (adv.adv2),
    .prod_i (prod),
    .sum_o  (sum)
  );

  y2r_pack u_pack (
    .clk_i  (clk_i),
    .en_i   (adv.adv3),
    .bgr_i  (bgr_q),
    .sum_i  (sum),
    .data_o (out_data_o)
  );

  assign in_stall_o  = !adv.adv1;
  assign out_valid_o = v3_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("item did not reach output after three free cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output item dropped");

endmodule

FILE: test/yuyv_to_rgb24_converter_tb.sv
`timescale 1ns / 100ps

module yuyv_to_rgb24_converter_tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned PhaseItems    = 220;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  y2r_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  y2r_pkg::out_t out_data_o;
  logic          cfg_we_i    = 1'b0;
  logic          cfg_wdata_i = 1'b0;

  y2r_pkg::in_t  pending_px[$];
  y2r_pkg::out_t rgb_expected[$];

  bit          bgr_mode     = 1'b0;
  bit          send_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned send_gap     = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned px_sent      = 0;
  int unsigned px_checked   = 0;
  int unsigned frame_marks  = 0;
  int unsigned bgr_items    = 0;
  int unsigned mismatches   = 0;

  yuyv_to_rgb24_converter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] clamp_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [23:0] rgb_pixel(logic [7:0] luma, int d, int e, bit bgr);
    int c;
    int r;
    int g;
    int b;
    c = int'(luma) - 16;
    r = (298 * c + 409 * e + 128) >>> 8;
    g = (298 * c - 100 * d - 208 * e + 128) >>> 8;
    b = (298 * c + 516 * d + 128) >>> 8;
    if (bgr) return {clamp_byte(b), clamp_byte(g), clamp_byte(r)};
    return {clamp_byte(r), clamp_byte(g), clamp_byte(b)};
  endfunction

  function automatic y2r_pkg::out_t convert_macropixel(y2r_pkg::in_t px, bit bgr);
    y2r_pkg::out_t res;
    int            d;
    int            e;
    d = int'(px.chroma_blue) - 128;
    e = int'(px.chroma_red) - 128;
    {res.first_lead, res.first_mid, res.first_tail} = rgb_pixel(px.luma_first, d, e, bgr);
    {res.second_lead, res.second_mid, res.second_tail} =
        rgb_pixel(px.luma_second, d, e, bgr);
    res.frame_end_out = px.frame_end_in;
    return res;
  endfunction

  function automatic int unsigned pick_gap(bit enable);
    int unsigned roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sample(int unsigned style, bit chroma);
    logic [7:0] rims[10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd127, 8'd128,
                             8'd235, 8'd240, 8'd254, 8'd255};
    if (style == 2) begin
      return chroma ? 8'($urandom_range(16, 240)) : 8'($urandom_range(16, 235));
    end
    if (style == 3) return rims[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic y2r_pkg::in_t random_macropixel();
    y2r_pkg::in_t px;
    int unsigned  style;
    style = $urandom_range(0, 3);
    px.luma_first   = pick_sample(style, 1'b0);
    px.chroma_blue  = pick_sample(style, 1'b1);
    px.luma_second  = pick_sample(style, 1'b0);
    px.chroma_red   = pick_sample(style, 1'b1);
    px.frame_end_in = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  task automatic check_byte(string tag, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s expected %0d, got %0d", $time, px_checked, tag, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_px.size() != 0 || in_valid_i || rgb_expected.size() != 0);
  endtask

  task automatic set_byte_order(bit bgr);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bgr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    bgr_mode = bgr;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rgb_expected.push_back(convert_macropixel(in_data_i, bgr_mode));
        px_sent++;
        if (in_data_i.frame_end_in) frame_marks++;
        if (bgr_mode) bgr_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_px.size() != 0) begin
          in_data_i  <= pending_px.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= pick_gap(send_idle_en);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rgb_monitor
    y2r_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rgb_expected.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, out_data_o);
          mismatches++;
        end else begin
          want = rgb_expected.pop_front();
          check_byte("first_lead", want.first_lead, out_data_o.first_lead);
          check_byte("first_mid", want.first_mid, out_data_o.first_mid);
          check_byte("first_tail", want.first_tail, out_data_o.first_tail);
          check_byte("second_lead", want.second_lead, out_data_o.second_lead);
          check_byte("second_mid", want.second_mid, out_data_o.second_mid);
          check_byte("second_tail", want.second_tail, out_data_o.second_tail);
          check_byte("frame_end_out", 8'(want.frame_end_out), 8'(out_data_o.frame_end_out));
          px_checked++;
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        hold_left   <= pick_gap(sink_idle_en);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, rgb_expected.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    y2r_pkg::in_t corners[12];
    corners = '{
      {8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
      {8'd255, 8'd255, 8'd255, 8'd255, 1'b1},
      {8'd16,  8'd128, 8'd235, 8'd128, 1'b0},
      {8'd0,   8'd128, 8'd255, 8'd128, 1'b1},
      {8'd128, 8'd0,   8'd128, 8'd255, 1'b0},
      {8'd128, 8'd255, 8'd128, 8'd0,   1'b0},
      {8'd235, 8'd0,   8'd16,  8'd0,   1'b0},
      {8'd235, 8'd255, 8'd16,  8'd255, 1'b1},
      {8'd16,  8'd240, 8'd235, 8'd16,  1'b0},
      {8'd15,  8'd127, 8'd236, 8'd129, 1'b0},
      {8'd81,  8'd90,  8'd145, 8'd240, 1'b0},
      {8'd170, 8'd166, 8'd41,  8'd16,  1'b1}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (corners[i]) pending_px.push_back(corners[i]);
    set_byte_order(1'b1);
    foreach (corners[i]) pending_px.push_back(corners[i]);
    for (int p = 0; p < RandPhases; p++) begin
      set_byte_order(p[0]);
      send_idle_en = (p != 1 && p != 3);
      sink_idle_en = (p != 1 && p != 2);
      repeat (PhaseItems) pending_px.push_back(random_macropixel());
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d macropixels, %0d in B,G,R order, %0d with frame end set",
             px_sent, bgr_items, frame_marks);
    $display("Checked %0d results, %0d mismatches", px_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: yuyv_to_rgb24_converter.f
design/y2r_pkg.sv
design/y2r_mul.sv
design/y2r_add.sv
design/y2r_pack.sv
design/yuyv_to_rgb24_converter.sv
test/yuyv_to_rgb24_converter_tb.sv
